// ----- src/rtk_pkg.sv -----
package rtk_pkg;

   // Schedule store size and the widths that follow from it.
   localparam int unsigned SchedDepth = 16;
   localparam int unsigned SchedAw    = (SchedDepth > 1) ? $clog2(SchedDepth) : 1;
   localparam int unsigned SchedCw    = $clog2(SchedDepth + 1);

   // Field and datapath widths.
   localparam int unsigned VecW   = 40;          // Q24.16 vector element
   localparam int unsigned DtW    = 20;          // frame time
   localparam int unsigned MulW   = 42;          // multiplier operand
   localparam int unsigned ProdW  = 84;          // multiplier product
   localparam int unsigned ExtW   = 88;          // signed work width
   localparam int unsigned RootW  = 42;          // square root result
   localparam int unsigned SremW  = 46;          // square root remainder
   localparam int unsigned DivW   = 82;          // dividend and quotient
   localparam int unsigned DremW  = 43;          // divider remainder
   localparam int unsigned CntW   = 7;           // iteration counter
   localparam int unsigned ReqDw  = 280;
   localparam int unsigned RspDw  = 240;
   localparam int unsigned CsrAw  = 3;

   // Input item kinds.
   typedef enum logic [1:0] {
      KIND_TICK  = 2'd0,
      KIND_SCHED = 2'd1,
      KIND_INIT  = 2'd2,
      KIND_NONE  = 2'd3
   } kind_type;

   // Register indexes on the configuration port.
   localparam logic [CsrAw-1:0] CSR_STATION_X = 3'd0;
   localparam logic [CsrAw-1:0] CSR_STATION_Y = 3'd1;
   localparam logic [CsrAw-1:0] CSR_STATION_Z = 3'd2;
   localparam logic [CsrAw-1:0] CSR_STEP_TIME = 3'd3;
   localparam logic [CsrAw-1:0] CSR_NOISE_EN  = 3'd4;

   // Sequencer states.
   typedef enum logic [4:0] {
      ST_IDLE,
      ST_MUL,
      ST_SQRT,
      ST_DIV,
      ST_AMUL,
      ST_ADT,
      ST_PMUL,
      ST_POS,
      ST_GROUND,
      ST_SQM,
      ST_SQ,
      ST_RTS,
      ST_ROOT_R,
      ST_ROOT_H,
      ST_DOTM,
      ST_DOT,
      ST_RADS,
      ST_RAD,
      ST_ELEVS,
      ST_ELEV,
      ST_AZIMS,
      ST_AZIM,
      ST_UPDATE,
      ST_OUT
   } state_type;

   localparam logic signed [ExtW-1:0] Sat40Max = 88'sh7F_FFFF_FFFF;
   localparam logic signed [ExtW-1:0] Sat40Min = -88'sh80_0000_0000;

   // Clip a wide signed value into the Q24.16 range.
   function automatic logic signed [VecW-1:0] sat40(input logic signed [ExtW-1:0] x);
      logic signed [VecW-1:0] r;
      if (x > Sat40Max) begin
         r = Sat40Max[VecW-1:0];
      end else if (x < Sat40Min) begin
         r = Sat40Min[VecW-1:0];
      end else begin
         r = x[VecW-1:0];
      end
      return r;
   endfunction

endpackage

// ----- src/radar_target_kinematics_step.sv -----
// Channel | Dir | Fields
// req     | in  | tuser: kind; tdata: event_time, vec_a_x/y/z, init_speed_x/y/z
// rsp     | out | tuser: ground_hit, schedule_applied; tdata: pos_x/y/z, radial_speed,
//         |     |        range_out, elevation_sine, azimuth_ratio
// csr     | in  | csr_index, csr_data (write only, always ready)
//
// A tick uses one shift-add multiplier (20 steps against dt, 41 steps otherwise),
// a two-bit-per-step square root (42 steps, run twice) and a restoring divider
// (82 steps, run up to three times). Schedule appends, init and unknown kinds are
// handled while idle and give no result. req_tready is high only while idle; a
// halted tick goes from idle straight to the result, and a tick that reaches the
// ground skips the range and angle steps. Reset is synchronous; it clears state,
// target, station, noise enable and schedule counters and sets dt to 65536.
module radar_target_kinematics_step (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   // event_time, vec_a_x, vec_a_y, vec_a_z, init_speed_x, init_speed_y, init_speed_z
   input  logic [rtk_pkg::ReqDw-1:0]   req_tdata,
   // kind
   input  logic [1:0]                  req_tuser,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // pos_x, pos_y, pos_z, radial_speed, range_out, elevation_sine, azimuth_ratio, pad
   output logic [rtk_pkg::RspDw-1:0]   rsp_tdata,
   // ground_hit, schedule_applied
   output logic [1:0]                  rsp_tuser,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [rtk_pkg::CsrAw-1:0]   csr_index,
   input  logic [rtk_pkg::VecW-1:0]    csr_data
);
   import rtk_pkg::*;

   // Configuration registers.
   logic signed [VecW-1:0] stn_ff [3];
   logic signed [VecW-1:0] stn_in [3];
   logic [DtW-1:0]         dt_ff, dt_in;
   logic                   noise_en_ff, noise_en_in;

   // Target state.
   logic signed [VecW-1:0] pos_ff [3];
   logic signed [VecW-1:0] pos_in [3];
   logic signed [VecW-1:0] vel_ff [3];
   logic signed [VecW-1:0] vel_in [3];
   logic signed [VecW-1:0] acc_ff [3];
   logic signed [VecW-1:0] acc_in [3];
   logic                   halted_ff, halted_in;

   // Schedule store.
   logic [VecW-1:0]        stime_ff [SchedDepth];
   logic [VecW-1:0]        stime_in [SchedDepth];
   logic signed [VecW-1:0] sacc_ff [SchedDepth][3];
   logic signed [VecW-1:0] sacc_in [SchedDepth][3];
   logic [SchedCw-1:0]     slen_ff, slen_in;
   logic [SchedCw-1:0]     snext_ff, snext_in;

   // Per-tick work registers.
   logic [VecW-1:0]        ev_ff, ev_in;
   logic signed [VecW-1:0] noise_ff [3];
   logic signed [VecW-1:0] noise_in [3];
   logic signed [VecW-1:0] adt_ff [3];
   logic signed [VecW-1:0] adt_in [3];
   logic signed [VecW:0]   d_ff [3];
   logic signed [VecW:0]   d_in [3];
   logic [1:0]             ax_ff, ax_in;
   logic [ProdW-1:0]       sq_ff, sq_in, sqh_ff, sqh_in;
   logic signed [ProdW:0]  dot_ff, dot_in;
   logic [RootW-1:0]       r_ff, r_in, h_ff, h_in;

   // Sequencer.
   state_type              state_ff, state_in, ret_ff, ret_in;
   logic [CntW-1:0]        cnt_ff, cnt_in;

   // Shared multiplier.
   logic [ProdW-1:0]       ma_ff, ma_in, mp_ff, mp_in;
   logic [MulW-1:0]        mb_ff, mb_in;
   logic                   mneg_ff, mneg_in;

   // Square root unit.
   logic [ProdW-1:0]       sop_ff, sop_in;
   logic [SremW-1:0]       srem_ff, srem_in;
   logic [RootW-1:0]       sroot_ff, sroot_in;

   // Divider.
   logic [DivW-1:0]        dnum_ff, dnum_in, dq_ff, dq_in;
   logic [DremW-1:0]       drem_ff, drem_in;
   logic [RootW-1:0]       dden_ff, dden_in;

   // Result registers.
   logic [VecW-1:0]        o_rad_ff, o_rad_in;
   logic [VecW-2:0]        o_rng_ff, o_rng_in;
   logic [17:0]            o_elev_ff, o_elev_in, o_azim_ff, o_azim_in;
   logic                   o_gnd_ff, o_gnd_in, o_app_ff, o_app_in;

   // Combinational helpers.
   logic signed [ExtW-1:0] mprod, rnd16, rnd17, psum, asum [3], vsum [3];
   logic signed [VecW-1:0] adt_val;
   logic signed [MulW-1:0] vs2;
   logic [MulW-1:0]        vs2_mag;
   logic [VecW-1:0]        acc_mag, vel_mag;
   logic [VecW:0]          d_mag;
   logic [SremW-1:0]       s_sh, s_trial;
   logic [DremW:0]         dv_sh;
   logic [DivW-1:0]        dot_mag;
   logic signed [VecW-1:0] acc_tmp [3];
   logic [VecW-1:0]        q_rad;
   logic [17:0]            q_ratio;
   logic [SchedAw-1:0]     sidx, snidx;

   assign sidx  = slen_ff[SchedAw-1:0];
   assign snidx = snext_ff[SchedAw-1:0];

   // Signed view of the multiplier product and its rounded shifts.
   assign mprod  = mneg_ff ? -$signed({4'b0, mp_ff}) : $signed({4'b0, mp_ff});
   assign rnd16  = mprod + 88'sd32768;
   assign rnd17  = mprod + 88'sd65536;
   assign adt_val = sat40(rnd16 >>> 16);
   assign psum   = (rnd17 >>> 17) + ExtW'(pos_ff[ax_ff]);

   // Operand magnitudes for the current axis.
   assign acc_mag = acc_ff[ax_ff][VecW-1] ? $unsigned(-acc_ff[ax_ff]) : $unsigned(acc_ff[ax_ff]);
   assign vel_mag = vel_ff[ax_ff][VecW-1] ? $unsigned(-vel_ff[ax_ff]) : $unsigned(vel_ff[ax_ff]);
   assign d_mag   = d_ff[ax_ff][VecW] ? $unsigned(-d_ff[ax_ff]) : $unsigned(d_ff[ax_ff]);
   assign vs2     = MulW'(vel_ff[ax_ff]) * 42'sd2 + MulW'(adt_ff[ax_ff]);
   assign vs2_mag = vs2[MulW-1] ? $unsigned(-vs2) : $unsigned(vs2);
   assign dot_mag = dot_ff[ProdW] ? DivW'($unsigned(-dot_ff)) : DivW'($unsigned(dot_ff));

   // Square root and divider step values.
   assign s_sh    = {srem_ff[SremW-3:0], sop_ff[ProdW-1 -: 2]};
   assign s_trial = SremW'({sroot_ff, 2'b01});
   assign dv_sh   = {drem_ff, dnum_ff[DivW-1]};

   // Saturated quotients.
   assign q_rad   = (dq_ff > DivW'(40'h7F_FFFF_FFFF)) ? 40'h7F_FFFF_FFFF : dq_ff[VecW-1:0];
   assign q_ratio = (dq_ff > DivW'(18'd65536)) ? 18'd65536 : dq_ff[17:0];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         vsum[i] = ExtW'(vel_ff[i]) + ExtW'(adt_ff[i]);
         asum[i] = ExtW'(acc_ff[i]) + ExtW'(noise_ff[i]);
      end
   end

   // Sequencer: next state, unit steps and state updates.
   always_comb begin
      stn_in      = stn_ff;
      dt_in       = dt_ff;
      noise_en_in = noise_en_ff;
      pos_in      = pos_ff;
      vel_in      = vel_ff;
      acc_in      = acc_ff;
      halted_in   = halted_ff;
      stime_in    = stime_ff;
      sacc_in     = sacc_ff;
      slen_in     = slen_ff;
      snext_in    = snext_ff;
      ev_in       = ev_ff;
      noise_in    = noise_ff;
      adt_in      = adt_ff;
      d_in        = d_ff;
      ax_in       = ax_ff;
      sq_in       = sq_ff;
      sqh_in      = sqh_ff;
      dot_in      = dot_ff;
      r_in        = r_ff;
      h_in        = h_ff;
      state_in    = state_ff;
      ret_in      = ret_ff;
      cnt_in      = cnt_ff;
      ma_in       = ma_ff;
      mb_in       = mb_ff;
      mp_in       = mp_ff;
      mneg_in     = mneg_ff;
      sop_in      = sop_ff;
      srem_in     = srem_ff;
      sroot_in    = sroot_ff;
      dnum_in     = dnum_ff;
      dq_in       = dq_ff;
      drem_in     = drem_ff;
      dden_in     = dden_ff;
      o_rad_in    = o_rad_ff;
      o_rng_in    = o_rng_ff;
      o_elev_in   = o_elev_ff;
      o_azim_in   = o_azim_ff;
      o_gnd_in    = o_gnd_ff;
      o_app_in    = o_app_ff;
      acc_tmp     = acc_ff;

      // Configuration writes.
      if (csr_valid) begin
         unique case (csr_index)
            CSR_STATION_X: stn_in[0] = csr_data;
            CSR_STATION_Y: stn_in[1] = csr_data;
            CSR_STATION_Z: stn_in[2] = csr_data;
            CSR_STEP_TIME: dt_in = csr_data[DtW-1:0];
            CSR_NOISE_EN:  noise_en_in = csr_data[0];
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               unique case (kind_type'(req_tuser))
                  KIND_TICK: begin
                     ev_in = req_tdata[VecW-1:0];
                     for (int i = 0; i < 3; i++) begin
                        noise_in[i] = req_tdata[VecW*(1+i) +: VecW];
                     end
                     ax_in = 2'd0;
                     if (halted_ff) begin
                        o_rad_in  = '0;
                        o_rng_in  = '0;
                        o_elev_in = '0;
                        o_azim_in = '0;
                        o_gnd_in  = 1'b1;
                        o_app_in  = 1'b0;
                        state_in  = ST_OUT;
                     end else begin
                        state_in = ST_AMUL;
                     end
                  end
                  KIND_SCHED: begin
                     if (slen_ff < SchedCw'(SchedDepth)) begin
                        stime_in[sidx] = req_tdata[VecW-1:0];
                        for (int i = 0; i < 3; i++) begin
                           sacc_in[sidx][i] = req_tdata[VecW*(1+i) +: VecW];
                        end
                        slen_in = slen_ff + 1'b1;
                     end
                  end
                  KIND_INIT: begin
                     for (int i = 0; i < 3; i++) begin
                        pos_in[i] = req_tdata[VecW*(1+i) +: VecW];
                        vel_in[i] = req_tdata[VecW*(4+i) +: VecW];
                     end
                     halted_in = 1'b0;
                  end
                  KIND_NONE: ;
               endcase
            end
         end

         // Shift-add multiplier, one multiplier bit per beat of the loop.
         ST_MUL: begin
            if (mb_ff[0]) begin
               mp_in = mp_ff + ma_ff;
            end
            ma_in  = ma_ff << 1;
            mb_in  = mb_ff >> 1;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == CntW'(1)) begin
               state_in = ret_ff;
            end
         end

         // Square root, two radicand bits per step.
         ST_SQRT: begin
            if (s_sh >= s_trial) begin
               srem_in  = s_sh - s_trial;
               sroot_in = {sroot_ff[RootW-2:0], 1'b1};
            end else begin
               srem_in  = s_sh;
               sroot_in = {sroot_ff[RootW-2:0], 1'b0};
            end
            sop_in = sop_ff << 2;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == CntW'(1)) begin
               state_in = ret_ff;
            end
         end

         // Restoring divider, one quotient bit per step.
         ST_DIV: begin
            if (dv_sh >= (DremW+1)'(dden_ff)) begin
               drem_in = DremW'(dv_sh - (DremW+1)'(dden_ff));
               dq_in   = {dq_ff[DivW-2:0], 1'b1};
            end else begin
               drem_in = DremW'(dv_sh);
               dq_in   = {dq_ff[DivW-2:0], 1'b0};
            end
            dnum_in = dnum_ff << 1;
            cnt_in  = cnt_ff - 1'b1;
            if (cnt_ff == CntW'(1)) begin
               state_in = ret_ff;
            end
         end

         // a * dt for the current axis.
         ST_AMUL: begin
            ma_in    = ProdW'(acc_mag);
            mb_in    = MulW'(dt_ff);
            mp_in    = '0;
            mneg_in  = acc_ff[ax_ff][VecW-1];
            cnt_in   = CntW'(DtW);
            ret_in   = ST_ADT;
            state_in = ST_MUL;
         end

         ST_ADT: begin
            adt_in[ax_ff] = adt_val;
            state_in      = ST_PMUL;
         end

         // (2v + adt) * dt for the position step.
         ST_PMUL: begin
            ma_in    = ProdW'(vs2_mag);
            mb_in    = MulW'(dt_ff);
            mp_in    = '0;
            mneg_in  = vs2[MulW-1];
            cnt_in   = CntW'(DtW);
            ret_in   = ST_POS;
            state_in = ST_MUL;
         end

         ST_POS: begin
            pos_in[ax_ff] = sat40(psum);
            if (ax_ff == 2'd2) begin
               state_in = ST_GROUND;
            end else begin
               ax_in    = ax_ff + 1'b1;
               state_in = ST_AMUL;
            end
         end

         // Ground check, then speed update and station offsets.
         ST_GROUND: begin
            if (pos_ff[1] <= 0) begin
               halted_in = 1'b1;
               o_rad_in  = '0;
               o_rng_in  = '0;
               o_elev_in = '0;
               o_azim_in = '0;
               o_gnd_in  = 1'b1;
               o_app_in  = 1'b0;
               state_in  = ST_OUT;
            end else begin
               for (int i = 0; i < 3; i++) begin
                  vel_in[i] = sat40(vsum[i]);
                  d_in[i]   = (VecW+1)'(pos_ff[i]) - (VecW+1)'(stn_ff[i]);
               end
               sq_in    = '0;
               sqh_in   = '0;
               ax_in    = 2'd0;
               state_in = ST_SQM;
            end
         end

         // Squared offsets, summed in full and over the horizontal axes.
         ST_SQM: begin
            ma_in    = ProdW'(d_mag);
            mb_in    = MulW'(d_mag);
            mp_in    = '0;
            mneg_in  = 1'b0;
            cnt_in   = CntW'(VecW + 1);
            ret_in   = ST_SQ;
            state_in = ST_MUL;
         end

         ST_SQ: begin
            sq_in = sq_ff + mp_ff;
            if (ax_ff != 2'd1) begin
               sqh_in = sqh_ff + mp_ff;
            end
            if (ax_ff == 2'd2) begin
               state_in = ST_RTS;
            end else begin
               ax_in    = ax_ff + 1'b1;
               state_in = ST_SQM;
            end
         end

         ST_RTS: begin
            sop_in   = sq_ff;
            srem_in  = '0;
            sroot_in = '0;
            cnt_in   = CntW'(RootW);
            ret_in   = ST_ROOT_R;
            state_in = ST_SQRT;
         end

         ST_ROOT_R: begin
            r_in     = sroot_ff;
            sop_in   = sqh_ff;
            srem_in  = '0;
            sroot_in = '0;
            cnt_in   = CntW'(RootW);
            ret_in   = ST_ROOT_H;
            state_in = ST_SQRT;
         end

         ST_ROOT_H: begin
            h_in     = sroot_ff;
            o_rng_in = (r_ff > RootW'(39'h7F_FFFF_FFFF)) ? 39'h7F_FFFF_FFFF
                                                       : r_ff[VecW-2:0];
            dot_in   = '0;
            ax_in    = 2'd0;
            state_in = ST_DOTM;
         end

         // Signed dot product of speed and offset.
         ST_DOTM: begin
            ma_in    = ProdW'(vel_mag);
            mb_in    = MulW'(d_mag);
            mp_in    = '0;
            mneg_in  = vel_ff[ax_ff][VecW-1] ^ d_ff[ax_ff][VecW];
            cnt_in   = CntW'(VecW + 1);
            ret_in   = ST_DOT;
            state_in = ST_MUL;
         end

         ST_DOT: begin
            dot_in = dot_ff + (ProdW+1)'(mprod);
            if (ax_ff == 2'd2) begin
               state_in = ST_RADS;
            end else begin
               ax_in    = ax_ff + 1'b1;
               state_in = ST_DOTM;
            end
         end

         // Radial speed: dot product over range. The height axis is
         // selected here so that its offset is ready for the elevation.
         ST_RADS: begin
            ax_in = 2'd1;
            if (r_ff == '0) begin
               o_rad_in = '0;
               state_in = ST_ELEVS;
            end else begin
               dnum_in  = dot_mag;
               dden_in  = r_ff;
               drem_in  = '0;
               dq_in    = '0;
               cnt_in   = CntW'(DivW);
               ret_in   = ST_RAD;
               state_in = ST_DIV;
            end
         end

         ST_RAD: begin
            if (!dot_ff[ProdW]) begin
               o_rad_in = q_rad;
            end else if (dq_ff > DivW'(40'h80_0000_0000)) begin
               o_rad_in = 40'h80_0000_0000;
            end else begin
               o_rad_in = -dq_ff[VecW-1:0];
            end
            state_in = ST_ELEVS;
         end

         // Elevation sine: height offset over range; the z axis comes next.
         ST_ELEVS: begin
            ax_in = 2'd2;
            if (r_ff == '0) begin
               o_elev_in = '0;
               state_in  = ST_AZIMS;
            end else begin
               dnum_in  = DivW'({d_mag, 16'b0});
               dden_in  = r_ff;
               drem_in  = '0;
               dq_in    = '0;
               cnt_in   = CntW'(DivW);
               ret_in   = ST_ELEV;
               state_in = ST_DIV;
            end
         end

         ST_ELEV: begin
            o_elev_in = d_ff[1][VecW] ? -q_ratio : q_ratio;
            state_in  = ST_AZIMS;
         end

         // Azimuth ratio: z offset over horizontal range.
         ST_AZIMS: begin
            ax_in = 2'd2;
            if (h_ff == '0) begin
               o_azim_in = '0;
               state_in  = ST_UPDATE;
            end else begin
               dnum_in  = DivW'({d_mag, 16'b0});
               dden_in  = h_ff;
               drem_in  = '0;
               dq_in    = '0;
               cnt_in   = CntW'(DivW);
               ret_in   = ST_AZIM;
               state_in = ST_DIV;
            end
         end

         ST_AZIM: begin
            o_azim_in = d_ff[2][VecW] ? -q_ratio : q_ratio;
            state_in  = ST_UPDATE;
         end

         // Noise, then a due schedule entry, into the acceleration.
         ST_UPDATE: begin
            if (noise_en_ff) begin
               for (int i = 0; i < 3; i++) begin
                  acc_tmp[i] = sat40(asum[i]);
               end
            end
            o_app_in = 1'b0;
            if (snext_ff < slen_ff && stime_ff[snidx] <= ev_ff) begin
               for (int i = 0; i < 3; i++) begin
                  acc_tmp[i] = sacc_ff[snidx][i];
               end
               snext_in = snext_ff + 1'b1;
               o_app_in = 1'b1;
            end
            acc_in   = acc_tmp;
            o_gnd_in = 1'b0;
            state_in = ST_OUT;
         end

         ST_OUT: begin
            if (rsp_tready) begin
               state_in = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // Control and architectural state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         halted_ff   <= 1'b0;
         slen_ff     <= '0;
         snext_ff    <= '0;
         dt_ff       <= DtW'(65536);
         noise_en_ff <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            stn_ff[i] <= '0;
            pos_ff[i] <= '0;
            vel_ff[i] <= '0;
            acc_ff[i] <= '0;
         end
      end else begin
         state_ff    <= state_in;
         halted_ff   <= halted_in;
         slen_ff     <= slen_in;
         snext_ff    <= snext_in;
         dt_ff       <= dt_in;
         noise_en_ff <= noise_en_in;
         stn_ff      <= stn_in;
         pos_ff      <= pos_in;
         vel_ff      <= vel_in;
         acc_ff      <= acc_in;
      end
   end

   // Work and payload registers.
   always_ff @(posedge clock) begin
      stime_ff  <= stime_in;
      sacc_ff   <= sacc_in;
      ev_ff     <= ev_in;
      noise_ff  <= noise_in;
      adt_ff    <= adt_in;
      d_ff      <= d_in;
      ax_ff     <= ax_in;
      sq_ff     <= sq_in;
      sqh_ff    <= sqh_in;
      dot_ff    <= dot_in;
      r_ff      <= r_in;
      h_ff      <= h_in;
      ret_ff    <= ret_in;
      cnt_ff    <= cnt_in;
      ma_ff     <= ma_in;
      mb_ff     <= mb_in;
      mp_ff     <= mp_in;
      mneg_ff   <= mneg_in;
      sop_ff    <= sop_in;
      srem_ff   <= srem_in;
      sroot_ff  <= sroot_in;
      dnum_ff   <= dnum_in;
      dq_ff     <= dq_in;
      drem_ff   <= drem_in;
      dden_ff   <= dden_in;
      o_rad_ff  <= o_rad_in;
      o_rng_ff  <= o_rng_in;
      o_elev_ff <= o_elev_in;
      o_azim_ff <= o_azim_in;
      o_gnd_ff  <= o_gnd_in;
      o_app_ff  <= o_app_in;
   end

   // Ports.
   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = (state_ff == ST_OUT);
   assign rsp_tdata  = {5'b0, o_azim_ff, o_elev_ff, o_rng_ff, o_rad_ff,
                        pos_ff[2], pos_ff[1], pos_ff[0]};
   assign rsp_tuser  = {o_app_ff, o_gnd_ff};

endmodule

// ----- test/tb_top.sv -----
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import rtk_pkg::*;

   localparam int unsigned HoldCycles = 3000;
   localparam int unsigned PhaseItems = 150;

   typedef struct {
      kind_type          kind;
      logic [39:0]       etime;
      logic signed [39:0] va[3];
      logic signed [39:0] vs[3];
   } req_beat_type;

   typedef struct {
      logic [39:0] pos[3];
      logic [39:0] radial;
      logic [38:0] range_q;
      logic [17:0] elev;
      logic [17:0] azim;
      logic        ground;
      logic        applied;
   } rsp_beat_type;

   // Scoreboard: tracks the target, predicts each tick's report and checks it.
   class kinematics_board;
      logic signed [39:0] stn[3];
      logic [19:0]        dt;
      logic               noise_on;
      logic signed [39:0] pos[3];
      logic signed [39:0] vel[3];
      logic signed [39:0] acc[3];
      logic [39:0]        plan_time[SchedDepth];
      logic signed [39:0] plan_acc[SchedDepth][3];
      int                 plan_len;
      int                 plan_next;
      bit                 halted;
      rsp_beat_type       reports[$];
      int                 errors;

      function new();
         stn = '{0, 0, 0};
         dt = 20'd65536;
         noise_on = 1'b0;
         pos = '{0, 0, 0};
         vel = '{0, 0, 0};
         acc = '{0, 0, 0};
         plan_len = 0;
         plan_next = 0;
         halted = 0;
         errors = 0;
      endfunction

      function void write_reg(logic [CsrAw-1:0] idx, logic [39:0] data);
         case (idx)
            CSR_STATION_X: stn[0] = data;
            CSR_STATION_Y: stn[1] = data;
            CSR_STATION_Z: stn[2] = data;
            CSR_STEP_TIME: dt = data[19:0];
            CSR_NOISE_EN:  noise_on = data[0];
            default: ;
         endcase
      endfunction

      function logic signed [39:0] clip40(logic signed [127:0] x);
         if (x > 128'sh7F_FFFF_FFFF) return 40'sh7F_FFFF_FFFF;
         if (x < -128'sh80_0000_0000) return 40'sh80_0000_0000;
         return x[39:0];
      endfunction

      // Round half up: floor((x + half) / 2^s).
      function logic signed [127:0] round_shr(logic signed [127:0] x, int s);
         return (x + (128'sd1 <<< (s - 1))) >>> s;
      endfunction

      function logic [127:0] floor_root(logic [127:0] n);
         logic [127:0] r;
         logic [127:0] c;
         r = 0;
         for (int b = 43; b >= 0; b--) begin
            c = r | (128'd1 << b);
            if (c * c <= n) r = c;
         end
         return r;
      endfunction

      // Signed Q1.16 ratio, truncated and clipped to one.
      function logic [17:0] unit_ratio(logic signed [127:0] num, logic [127:0] den);
         logic [127:0] m;
         if (den == 0) return 18'd0;
         m = ((num < 0) ? -num : num) << 16;
         m = m / den;
         if (m > 65536) m = 65536;
         return (num < 0) ? -m[17:0] : m[17:0];
      endfunction

      function void note_input(req_beat_type it);
         logic signed [127:0] dts, w, dot;
         logic signed [127:0] d[3];
         logic signed [39:0]  adt[3];
         logic [127:0]        sqh, sq, r, h, q;
         rsp_beat_type        exp_r;
         case (it.kind)
            KIND_SCHED: begin
               if (plan_len < SchedDepth) begin
                  plan_time[plan_len] = it.etime;
                  for (int i = 0; i < 3; i++) plan_acc[plan_len][i] = it.va[i];
                  plan_len++;
               end
            end
            KIND_INIT: begin
               for (int i = 0; i < 3; i++) begin
                  pos[i] = it.va[i];
                  vel[i] = it.vs[i];
               end
               halted = 0;
            end
            KIND_TICK: begin
               exp_r.radial = 0;
               exp_r.range_q = 0;
               exp_r.elev = 0;
               exp_r.azim = 0;
               exp_r.applied = 0;
               if (!halted) begin
                  dts = dt;
                  for (int i = 0; i < 3; i++) begin
                     w = acc[i];
                     adt[i] = clip40(round_shr(w * dts, 16));
                     w = vel[i];
                     w = w + w + adt[i];
                     pos[i] = clip40(pos[i] + round_shr(w * dts, 17));
                  end
                  if (pos[1] <= 0) begin
                     halted = 1;
                  end else begin
                     dot = 0;
                     for (int i = 0; i < 3; i++) begin
                        w = vel[i];
                        vel[i] = clip40(w + adt[i]);
                        d[i] = pos[i];
                        d[i] = d[i] - stn[i];
                        w = vel[i];
                        dot = dot + w * d[i];
                     end
                     sqh = d[0] * d[0] + d[2] * d[2];
                     sq = sqh + d[1] * d[1];
                     r = floor_root(sq);
                     h = floor_root(sqh);
                     exp_r.range_q = (r > 128'h7F_FFFF_FFFF) ? 39'h7F_FFFF_FFFF : r[38:0];
                     if (r != 0) begin
                        if (dot >= 0) begin
                           q = dot / r;
                           exp_r.radial = (q > 128'h7F_FFFF_FFFF) ? 40'h7F_FFFF_FFFF : q[39:0];
                        end else begin
                           q = (-dot) / r;
                           if (q > 128'h80_0000_0000) q = 128'h80_0000_0000;
                           exp_r.radial = -q[39:0];
                        end
                     end
                     exp_r.elev = unit_ratio(d[1], r);
                     exp_r.azim = unit_ratio(d[2], h);
                     if (noise_on) begin
                        for (int i = 0; i < 3; i++) begin
                           w = acc[i];
                           acc[i] = clip40(w + it.va[i]);
                        end
                     end
                     if (plan_next < plan_len && plan_time[plan_next] <= it.etime) begin
                        for (int i = 0; i < 3; i++) acc[i] = plan_acc[plan_next][i];
                        plan_next++;
                        exp_r.applied = 1;
                     end
                  end
               end
               if (halted) begin
                  exp_r.radial = 0;
                  exp_r.range_q = 0;
                  exp_r.elev = 0;
                  exp_r.azim = 0;
               end
               for (int i = 0; i < 3; i++) exp_r.pos[i] = pos[i];
               exp_r.ground = halted;
               reports.push_back(exp_r);
            end
            default: ;
         endcase
      endfunction

      function void match(string name, logic [63:0] e, logic [63:0] a);
         if (e !== a) begin
            $error("%s: expected %h, got %h", name, e, a);
            errors++;
         end
      endfunction

      function void check_result(rsp_beat_type act);
         rsp_beat_type e;
         if (reports.size() == 0) begin
            $error("report beat arrived with none expected");
            errors++;
            return;
         end
         e = reports.pop_front();
         match("pos_x", e.pos[0], act.pos[0]);
         match("pos_y", e.pos[1], act.pos[1]);
         match("pos_z", e.pos[2], act.pos[2]);
         match("radial_speed", e.radial, act.radial);
         match("range_out", e.range_q, act.range_q);
         match("elevation_sine", e.elev, act.elev);
         match("azimuth_ratio", e.azim, act.azim);
         match("ground_hit", e.ground, act.ground);
         match("schedule_applied", e.applied, act.applied);
      endfunction

      function int pending();
         return reports.size();
      endfunction
   endclass

   logic                clock = 1'b0;
   logic                reset;
   logic                req_tvalid;
   logic                req_tready;
   logic [ReqDw-1:0]    req_tdata;
   logic [1:0]          req_tuser;
   logic                rsp_tvalid;
   logic                rsp_tready;
   logic [RspDw-1:0]    rsp_tdata;
   logic [1:0]          rsp_tuser;
   logic                csr_valid;
   logic                csr_ready;
   logic [CsrAw-1:0]    csr_index;
   logic [VecW-1:0]     csr_data;

   kinematics_board board = new();
   bit          quiet;
   bit          hold_req;
   logic [39:0] sim_clock_t;
   int          counted;

   radar_target_kinematics_step u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic logic [39:0] rand40();
      logic [63:0] t;
      t = {$urandom(), $urandom()};
      return t[39:0];
   endfunction

   // Signed random value within about +/- 2^n.
   function automatic logic signed [39:0] rand_span(int n);
      logic signed [39:0] v;
      v = rand40();
      return v >>> (39 - n);
   endfunction

   function automatic int draw_gap();
      if (quiet) return 0;
      return $urandom_range(16, 0);
   endfunction

   task automatic csr_write(logic [CsrAw-1:0] idx, logic [39:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      board.write_reg(idx, data);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Drives at a falling edge after a random idle gap and returns just after the accepting
   // rising edge; the next beat or the drain replaces it at the falling edge.
   task automatic send(req_beat_type it);
      int gap;
      gap = draw_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= it.kind;
      req_tdata  <= {it.vs[2], it.vs[1], it.vs[0], it.va[2], it.va[1], it.va[0], it.etime};
      do @(posedge clock); while (!req_tready);
      board.note_input(it);
      counted++;
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   function automatic req_beat_type make_beat(kind_type k, logic [39:0] t,
         logic signed [39:0] ax, logic signed [39:0] ay, logic signed [39:0] az,
         logic signed [39:0] sx, logic signed [39:0] sy, logic signed [39:0] sz);
      req_beat_type it;
      it.kind = k;
      it.etime = t;
      it.va = '{ax, ay, az};
      it.vs = '{sx, sy, sz};
      return it;
   endfunction

   // Random traffic: mostly fly-and-tick sequences, with some full-range noise.
   function automatic req_beat_type random_beat();
      req_beat_type it;
      int        sel;
      bit        wild;
      sel  = $urandom_range(99, 0);
      wild = ($urandom_range(7, 0) == 0);
      for (int i = 0; i < 3; i++) begin
         it.va[i] = rand40();
         it.vs[i] = rand40();
      end
      it.etime = rand40();
      if (sel < 60) begin
         it.kind = KIND_TICK;
         if (!wild) begin
            sim_clock_t += board.dt;
            it.etime = sim_clock_t;
            for (int i = 0; i < 3; i++) it.va[i] = rand_span(20);
         end
      end else if (sel < 78) begin
         it.kind = KIND_INIT;
         if (!wild) begin
            it.va[0] = rand_span(34);
            it.va[1] = $urandom_range(32'h7FFF_FFFF, 1);
            it.va[2] = rand_span(34);
            for (int i = 0; i < 3; i++) it.vs[i] = rand_span(25);
         end
      end else if (sel < 96) begin
         it.kind = KIND_SCHED;
         if (!wild) begin
            it.etime = sim_clock_t + $urandom_range(32'h40000, 0);
            for (int i = 0; i < 3; i++) it.va[i] = rand_span(22);
         end
      end else begin
         it.kind = KIND_NONE;
      end
      return it;
   endfunction

   // Report side: random stalls, plus one long hold-off on request.
   initial begin
      rsp_beat_type act;
      int        stall;
      rsp_tready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         stall = draw_gap();
         if (hold_req) begin
            stall = HoldCycles;
            hold_req = 0;
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         for (int i = 0; i < 3; i++) act.pos[i] = rsp_tdata[40*i +: 40];
         act.radial  = rsp_tdata[159:120];
         act.range_q = rsp_tdata[198:160];
         act.elev    = rsp_tdata[216:199];
         act.azim    = rsp_tdata[234:217];
         act.ground  = rsp_tuser[0];
         act.applied = rsp_tuser[1];
         board.check_result(act);
         @(negedge clock);
      end
   end

   initial begin
      #80_000_000;
      $display("** radar_target_kinematics_step: FAILED **");
      $finish;
   end

   initial begin
      logic signed [39:0] mx, mn, one_m;
      mx = 40'sh7F_FFFF_FFFF;
      mn = 40'sh80_0000_0000;
      one_m = 40'sd65536;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = KIND_TICK;
      csr_valid = 1'b0;
      csr_index = CSR_STATION_X;
      csr_data = '0;
      quiet = 0;
      hold_req = 0;
      sim_clock_t = 0;
      counted = 0;
      repeat (11) @(negedge clock);
      reset <= 1'b0;

      // Station at 1000 m height, no noise.
      csr_write(CSR_STATION_X, 0);
      csr_write(CSR_STATION_Y, 1000 * one_m);
      csr_write(CSR_STATION_Z, 0);
      csr_write(CSR_STEP_TIME, 65536);
      csr_write(CSR_NOISE_EN, 0);

      // Target on the station: zero range and zero horizontal range.
      send(make_beat(KIND_INIT, 0, 0, 1000 * one_m, 0, 0, 0, 0));
      send(make_beat(KIND_TICK, 0, 0, 0, 0, 0, 0, 0));
      // Straight above: zero horizontal range only.
      send(make_beat(KIND_INIT, 0, 0, 2000 * one_m, 0, 0, 0, 0));
      send(make_beat(KIND_TICK, 1, 0, 0, 0, 0, 0, 0));
      // Falls through the ground, then ticks while halted, then an unknown kind.
      send(make_beat(KIND_INIT, 0, 5 * one_m, one_m, 0, 0, -50 * one_m, 0));
      send(make_beat(KIND_TICK, 2, 0, 0, 0, 0, 0, 0));
      send(make_beat(KIND_TICK, 3, 0, 0, 0, 0, 0, 0));
      send(make_beat(KIND_NONE, 40'hFF_FFFF_FFFF, mx, mx, mx, mx, mx, mx));
      // Extreme speeds and schedule entries at both time extremes.
      send(make_beat(KIND_SCHED, 0, mx, mn, mx, 0, 0, 0));
      send(make_beat(KIND_SCHED, 40'hFF_FFFF_FFFF, mn, mx, mn, 0, 0, 0));
      send(make_beat(KIND_INIT, 0, mn, mx, mx, mx, mn, mx));
      send(make_beat(KIND_TICK, 0, 0, 0, 0, 0, 0, 0));
      send(make_beat(KIND_TICK, 40'hFF_FFFF_FFFF, 0, 0, 0, 0, 0, 0));
      wait_drained();

      // Far station for a range past the field, full noise at both extremes.
      csr_write(CSR_STATION_X, mn);
      csr_write(CSR_STATION_Z, mx);
      csr_write(CSR_NOISE_EN, 1);
      send(make_beat(KIND_INIT, 0, mx, 500 * one_m, mn, 10 * one_m, 0, -10 * one_m));
      send(make_beat(KIND_TICK, 5, mx, mx, mx, 0, 0, 0));
      send(make_beat(KIND_TICK, 6, mn, mn, mn, 0, 0, 0));
      send(make_beat(KIND_TICK, 7, mn, mn, mn, 0, 0, 0));
      wait_drained();

      // Zero and longest frame time.
      csr_write(CSR_STEP_TIME, 0);
      send(make_beat(KIND_INIT, 0, 0, 300 * one_m, 0, one_m, one_m, one_m));
      send(make_beat(KIND_TICK, 8, 0, 0, 0, 0, 0, 0));
      wait_drained();
      csr_write(CSR_STEP_TIME, 20'hFFFFF);
      send(make_beat(KIND_TICK, 9, 0, 0, 0, 0, 0, 0));
      wait_drained();

      // Random phases with fresh settings; one quiet, one with a long hold-off.
      for (int ph = 0; ph < 6; ph++) begin
         for (int i = 0; i < 3; i++)
            csr_write(CsrAw'(CSR_STATION_X + i), (ph == 5) ? rand40() : rand_span(30));
         case (ph)
            0: csr_write(CSR_STEP_TIME, 65536);
            1: csr_write(CSR_STEP_TIME, 20'hFFFFF);
            2: csr_write(CSR_STEP_TIME, 1);
            default: csr_write(CSR_STEP_TIME, $urandom_range(20'hFFFFF, 0));
         endcase
         csr_write(CSR_NOISE_EN, ph % 2);
         quiet = (ph == 3);
         hold_req = (ph == 2);
         counted = 0;
         while (counted < PhaseItems) send(random_beat());
         wait_drained();
      end

      repeat (50) @(posedge clock);
      if (board.errors == 0 && board.pending() == 0) begin
         $display("** radar_target_kinematics_step: PASSED **");
      end else begin
         $display("** radar_target_kinematics_step: FAILED **");
      end
      $finish;
   end

endmodule
